### rtl/core/bcpsq_pkg.sv
// Package for the byte-capped priority send queue.
// Holds the command and result word types, register indexes and default sizes.
// No dependencies.
`default_nettype none

package bcpsq_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned MAX_BATCH_DEF  = 64;

  localparam int unsigned CAP_W   = 24;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned BATCH_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CAP_W-1:0]   BYTE_CAP_RST      = 24'd65536;
  localparam logic [BATCH_W-1:0] DEFAULT_BATCH_RST = 7'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CLOSED  = 2'd2;

  // Command codes.
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic               action;
    logic               plain_class;
    logic               high_priority;
    logic [TAG_W-1:0]   frame_tag;
    logic [LEN_W-1:0]   frame_length;
    logic [BATCH_W-1:0] batch_limit;
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             has_frame;
    logic [TAG_W-1:0] out_tag;
    logic [LEN_W-1:0] out_length;
    logic             from_high;
    logic             last_of_batch;
    logic [CAP_W-1:0] pending_total;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/byte_capped_priority_send_queue.sv
// Top level of the byte-capped priority send queue: four descriptor rings in one
// synchronous memory, ring pointers, pending byte total and the drain sequencer.
// Depends on bcpsq_pkg.
`default_nettype none

// Usage: a word is taken at a clock edge where start is high and busy is low.
// A push is decided in the cycle it is taken and its single result appears on
// the next cycle; busy stays low, so pushes can follow one per cycle. A drain
// that finds nothing (zero limit or both rings of the class empty) also gives
// its single result on the next cycle. A drain of n frames reads one descriptor
// per cycle from the memory: busy stays high while the sequencer is draining
// and until its last read has left the read stage, and the n results appear
// on consecutive cycles, each passing through the descriptor memory's read
// register and then the output register. Each result is shown for exactly
// one cycle with res_strobe_o high; the receiver cannot hold results off.
module byte_capped_priority_send_queue #(
  parameter int unsigned RING_DEPTH = bcpsq_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_BATCH  = bcpsq_pkg::MAX_BATCH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  bcpsq_pkg::cmd_t                in_word_i,
  output logic                                 res_strobe_o,
  output bcpsq_pkg::res_t                      res_o,
  input  wire                                  cfg_we_i,
  input  wire  [bcpsq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [bcpsq_pkg::CAP_W-1:0]          cfg_wdata_i
);

  localparam int unsigned HW        = $clog2(RING_DEPTH);
  localparam int unsigned FW        = $clog2(RING_DEPTH + 1);
  localparam int unsigned AW        = FW + 1;
  localparam int unsigned MW        = HW + 2;
  localparam int unsigned MEM_DEPTH = 4 * (2 ** HW);
  localparam int unsigned CW        = $clog2(MAX_BATCH + 1);
  localparam int unsigned NW        = (AW > bcpsq_pkg::BATCH_W) ? AW : bcpsq_pkg::BATCH_W;
  localparam int unsigned DW        = bcpsq_pkg::TAG_W + bcpsq_pkg::LEN_W;

  // Configuration registers.
  logic [bcpsq_pkg::CAP_W-1:0]   byte_cap_q;
  logic [bcpsq_pkg::BATCH_W-1:0] default_batch_q;
  logic                          queue_closed_q;

  // Ring pointers and byte total.
  logic [HW-1:0] head_q [4];
  logic [HW-1:0] head_d [4];
  logic [FW-1:0] fill_q [4];
  logic [FW-1:0] fill_d [4];
  logic [bcpsq_pkg::CAP_W-1:0] pending_q, pending_d;

  // Drain sequencer.
  bcpsq_pkg::state_e state_q, state_d;
  logic          drn_cls_q, drn_cls_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Read pipeline stage.
  logic rd_valid_q, rd_valid_d;
  logic rd_hi_q, rd_hi_d;
  logic rd_last_q, rd_last_d;

  // Descriptor memory.
  logic [DW-1:0] mem [MEM_DEPTH];
  logic [DW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [MW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  // Result register.
  logic            res_valid_q, res_valid_d;
  bcpsq_pkg::res_t res_q, res_d;

  // Push decision.
  logic [1:0]                    push_ring;
  logic [bcpsq_pkg::CAP_W:0]     push_sum;
  logic                          push_ok;
  logic [AW-1:0]                 push_slot_w;
  logic [HW-1:0]                 push_slot;

  // Drain sizing.
  logic [bcpsq_pkg::BATCH_W-1:0] eff_lim;
  logic [AW-1:0]                 avail;
  logic [NW-1:0]                 n_w;

  // Drain step.
  logic          step_hi;
  logic [1:0]    step_ring;
  logic [HW:0]   head_inc;

  // Frame result.
  logic [bcpsq_pkg::LEN_W-1:0] rd_len;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_q != bcpsq_pkg::ST_IDLE) || rd_valid_q;

  always_comb begin
    push_ring   = {in_word_i.plain_class, ~in_word_i.high_priority};
    push_sum    = {1'b0, pending_q} + (bcpsq_pkg::CAP_W + 1)'(in_word_i.frame_length);
    push_ok     = !queue_closed_q && (push_sum <= {1'b0, byte_cap_q}) &&
                  (fill_q[push_ring] < FW'(RING_DEPTH));
    push_slot_w = AW'(head_q[push_ring]) + AW'(fill_q[push_ring]);
    if (push_slot_w >= AW'(RING_DEPTH)) begin
      push_slot_w = push_slot_w - AW'(RING_DEPTH);
    end
    push_slot = push_slot_w[HW-1:0];

    eff_lim = (in_word_i.batch_limit != '0) ? in_word_i.batch_limit : default_batch_q;
    if (eff_lim > bcpsq_pkg::BATCH_W'(MAX_BATCH)) begin
      eff_lim = bcpsq_pkg::BATCH_W'(MAX_BATCH);
    end
    avail = AW'(fill_q[{in_word_i.plain_class, 1'b0}]) +
            AW'(fill_q[{in_word_i.plain_class, 1'b1}]);
    n_w   = (NW'(eff_lim) < NW'(avail)) ? NW'(eff_lim) : NW'(avail);

    step_hi   = (fill_q[{drn_cls_q, 1'b0}] != '0);
    step_ring = {drn_cls_q, ~step_hi};
    head_inc  = (HW + 1)'(head_q[step_ring]) + (HW + 1)'(1);

    rd_len = rdata_q[bcpsq_pkg::LEN_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    drn_cls_d   = drn_cls_q;
    cnt_d       = cnt_q;
    pending_d   = pending_q;
    rd_valid_d  = 1'b0;
    rd_hi_d     = rd_hi_q;
    rd_last_d   = rd_last_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = {push_ring, push_slot};
    mem_wdata   = {in_word_i.frame_tag, in_word_i.frame_length};
    mem_raddr   = {step_ring, head_q[step_ring]};
    for (int i = 0; i < 4; i++) begin
      head_d[i] = head_q[i];
      fill_d[i] = fill_q[i];
    end

    case (state_q)
      bcpsq_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.last_of_batch = 1'b1;
          res_d.pending_total = pending_q;
          if (in_word_i.action == bcpsq_pkg::ACT_PUSH) begin
            if (push_ok) begin
              mem_we              = 1'b1;
              fill_d[push_ring]   = fill_q[push_ring] + FW'(1);
              pending_d           = push_sum[bcpsq_pkg::CAP_W-1:0];
              res_d.accepted      = 1'b1;
              res_d.pending_total = push_sum[bcpsq_pkg::CAP_W-1:0];
            end
          end else if (n_w != '0) begin
            // Non-empty drain: results come from the read pipeline instead.
            res_valid_d = 1'b0;
            drn_cls_d   = in_word_i.plain_class;
            cnt_d       = CW'(n_w);
            state_d     = bcpsq_pkg::ST_DRAIN;
          end
        end
      end
      bcpsq_pkg::ST_DRAIN: begin
        mem_re            = 1'b1;
        rd_valid_d        = 1'b1;
        rd_hi_d           = step_hi;
        rd_last_d         = (cnt_q == CW'(1));
        fill_d[step_ring] = fill_q[step_ring] - FW'(1);
        head_d[step_ring] = (head_inc == (HW + 1)'(RING_DEPTH)) ? '0 : head_inc[HW-1:0];
        cnt_d             = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = bcpsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcpsq_pkg::ST_IDLE;
      end
    endcase

    if (rd_valid_q) begin
      pending_d           = (pending_q >= bcpsq_pkg::CAP_W'(rd_len)) ?
                            pending_q - bcpsq_pkg::CAP_W'(rd_len) : '0;
      res_valid_d         = 1'b1;
      res_d.accepted      = 1'b0;
      res_d.has_frame     = 1'b1;
      res_d.out_tag       = rdata_q[DW-1:bcpsq_pkg::LEN_W];
      res_d.out_length    = rd_len;
      res_d.from_high     = rd_hi_q;
      res_d.last_of_batch = rd_last_q;
      res_d.pending_total = pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cap_q      <= bcpsq_pkg::BYTE_CAP_RST;
      default_batch_q <= bcpsq_pkg::DEFAULT_BATCH_RST;
      queue_closed_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcpsq_pkg::CFG_BYTE_CAP:      byte_cap_q      <= cfg_wdata_i;
        bcpsq_pkg::CFG_DEFAULT_BATCH: default_batch_q <= cfg_wdata_i[bcpsq_pkg::BATCH_W-1:0];
        bcpsq_pkg::CFG_QUEUE_CLOSED:  queue_closed_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcpsq_pkg::ST_IDLE;
      drn_cls_q   <= 1'b0;
      cnt_q       <= '0;
      pending_q   <= '0;
      rd_valid_q  <= 1'b0;
      rd_hi_q     <= 1'b0;
      rd_last_q   <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      drn_cls_q   <= drn_cls_d;
      cnt_q       <= cnt_d;
      pending_q   <= pending_d;
      rd_valid_q  <= rd_valid_d;
      rd_hi_q     <= rd_hi_d;
      rd_last_q   <= rd_last_d;
      res_valid_q <= res_valid_d;
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= head_d[i];
        fill_q[i] <= fill_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Writes happen only for pushes and reads only while draining, so the two
  // never touch the memory in the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

`ifndef SYNTHESIS
  a_no_mem_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("descriptor memory written and read in the same cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= FW'(RING_DEPTH)) && (fill_q[1] <= FW'(RING_DEPTH)) &&
    (fill_q[2] <= FW'(RING_DEPTH)) && (fill_q[3] <= FW'(RING_DEPTH)))
    else $error("ring fill count above ring depth");

  a_drain_ring_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcpsq_pkg::ST_DRAIN) |-> (fill_q[step_ring] != '0))
    else $error("drain step on an empty ring");

  a_last_step_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcpsq_pkg::ST_DRAIN && cnt_q == CW'(1)) |=> (rd_valid_q && rd_last_q))
    else $error("final drain read not marked as last");

  a_total_falls_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |=> (pending_q <= $past(pending_q)))
    else $error("pending byte total rose while draining");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the byte-capped priority send queue.
// Holds its own ring and byte-total model; depends on bcpsq_pkg and the top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcpsq_pkg::*;

  localparam int unsigned RING_DEPTH = RING_DEPTH_DEF;
  localparam int unsigned MAX_BATCH  = MAX_BATCH_DEF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 in_word_i = '0;
  logic                 res_strobe_o;
  res_t                 res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CAP_W-1:0]     cfg_wdata_i = '0;

  // Model of the queue state and its registers.
  logic [TAG_W-1:0] ring_tag [4][RING_DEPTH];
  logic [LEN_W-1:0] ring_len [4][RING_DEPTH];
  int unsigned      ring_head [4] = '{default: 0};
  int unsigned      ring_fill [4] = '{default: 0};
  int unsigned      model_total = 0;
  int unsigned      cap_bytes = BYTE_CAP_RST;
  int unsigned      batch_dflt = DEFAULT_BATCH_RST;
  bit               queue_shut = 1'b0;

  cmd_t        words_to_send [$];
  res_t        due_results [$];
  int unsigned gap_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned error_count = 0;
  int unsigned results_seen = 0;

  byte_capped_priority_send_queue #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_BATCH (MAX_BATCH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  // Applies one accepted word to the model and queues the results it causes.
  function automatic void compute_send_results(cmd_t w);
    res_t        r;
    int unsigned ring, slot, n, avail, rh, rl;
    r = '0;
    r.last_of_batch = 1'b1;
    if (w.action == ACT_PUSH) begin
      ring = 2 * w.plain_class + (w.high_priority ? 0 : 1);
      if (!queue_shut && model_total + w.frame_length <= cap_bytes &&
          ring_fill[ring] < RING_DEPTH) begin
        slot = (ring_head[ring] + ring_fill[ring]) % RING_DEPTH;
        ring_tag[ring][slot] = w.frame_tag;
        ring_len[ring][slot] = w.frame_length;
        ring_fill[ring]++;
        model_total += w.frame_length;
        r.accepted = 1'b1;
      end
      r.pending_total = CAP_W'(model_total);
      due_results.push_back(r);
    end else begin
      n = (w.batch_limit != 0) ? w.batch_limit : batch_dflt;
      if (n > MAX_BATCH) n = MAX_BATCH;
      rh = 2 * w.plain_class;
      rl = rh + 1;
      avail = ring_fill[rh] + ring_fill[rl];
      if (n > avail) n = avail;
      if (n == 0) begin
        r.pending_total = CAP_W'(model_total);
        due_results.push_back(r);
      end
      for (int unsigned k = 0; k < n; k++) begin
        // The high ring of the class is emptied before the low one is touched.
        ring = (ring_fill[rh] != 0) ? rh : rl;
        slot = ring_head[ring];
        r.has_frame = 1'b1;
        r.out_tag = ring_tag[ring][slot];
        r.out_length = ring_len[ring][slot];
        r.from_high = (ring == rh);
        ring_head[ring] = (slot + 1) % RING_DEPTH;
        ring_fill[ring]--;
        model_total = (model_total >= r.out_length) ? model_total - r.out_length : 0;
        r.last_of_batch = (k + 1 == n);
        r.pending_total = CAP_W'(model_total);
        due_results.push_back(r);
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: a word stays on the port until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_word_i <= '0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (start) compute_send_results(in_word_i);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        in_word_i <= words_to_send.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expected one.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_strobe_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("result arrived with none expected");
      end else begin
        want = due_results.pop_front();
        if (res_o.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0h, want %0h", res_o.accepted, want.accepted));
        if (res_o.has_frame !== want.has_frame)
          report_mismatch($sformatf("has_frame %0h, want %0h", res_o.has_frame,
                                    want.has_frame));
        if (res_o.out_tag !== want.out_tag)
          report_mismatch($sformatf("out_tag %0h, want %0h", res_o.out_tag, want.out_tag));
        if (res_o.out_length !== want.out_length)
          report_mismatch($sformatf("out_length %0h, want %0h", res_o.out_length,
                                    want.out_length));
        if (res_o.from_high !== want.from_high)
          report_mismatch($sformatf("from_high %0h, want %0h", res_o.from_high,
                                    want.from_high));
        if (res_o.last_of_batch !== want.last_of_batch)
          report_mismatch($sformatf("last_of_batch %0h, want %0h", res_o.last_of_batch,
                                    want.last_of_batch));
        if (res_o.pending_total !== want.pending_total)
          report_mismatch($sformatf("pending_total %0h, want %0h", res_o.pending_total,
                                    want.pending_total));
      end
      results_seen++;
    end
  end

  function automatic cmd_t make_push(bit plain, bit high, int unsigned tag, int unsigned len);
    cmd_t w;
    w = '0;
    w.action = ACT_PUSH;
    w.plain_class = plain;
    w.high_priority = high;
    w.frame_tag = TAG_W'(tag);
    w.frame_length = LEN_W'(len);
    return w;
  endfunction

  function automatic cmd_t make_drain(bit plain, int unsigned lim);
    cmd_t w;
    w = '0;
    w.action = ACT_DRAIN;
    w.plain_class = plain;
    w.batch_limit = BATCH_W'(lim);
    return w;
  endfunction

  // Waits until every word is taken and every expected result has come back.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    do @(negedge clk_i); while (words_to_send.size() != 0 || start);
    while (due_results.size() != 0 && waited < 500) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
      due_results.delete();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BYTE_CAP:      cap_bytes = data;
      CFG_DEFAULT_BATCH: batch_dflt = data[BATCH_W-1:0];
      CFG_QUEUE_CLOSED:  queue_shut = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned cap, int unsigned batch, bit shut);
    write_reg(CFG_BYTE_CAP, CAP_W'(cap));
    write_reg(CFG_DEFAULT_BATCH, CAP_W'(batch));
    write_reg(CFG_QUEUE_CLOSED, CAP_W'(shut));
  endtask

  // Random words, pushes at the given share and mostly short drains, so that
  // the rings and cap are reached; fields a word does not use are random as well.
  task automatic run_random(int unsigned count, int unsigned push_pct, int unsigned len_max,
                            int unsigned batch_max, bit with_gaps);
    cmd_t        w;
    int unsigned roll;
    gaps_on = with_gaps;
    repeat (count) begin
      w.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_DRAIN;
      w.plain_class = 1'($urandom_range(0, 1));
      w.high_priority = 1'($urandom_range(0, 1));
      w.frame_tag = TAG_W'($urandom);
      roll = $urandom_range(0, 19);
      if (roll == 0) w.frame_length = '0;
      else if (roll == 1) w.frame_length = '1;
      else w.frame_length = LEN_W'($urandom_range(0, len_max));
      roll = $urandom_range(0, 19);
      if (roll < 2) w.batch_limit = '0;
      else if (roll == 2) w.batch_limit = BATCH_W'(MAX_BATCH);
      else if (roll == 3) w.batch_limit = BATCH_W'($urandom_range(MAX_BATCH + 1, 127));
      else w.batch_limit = BATCH_W'($urandom_range(1, batch_max));
      words_to_send.push_back(w);
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset configuration.
    words_to_send.push_back(make_drain(1'b0, 0));
    words_to_send.push_back(make_push(1'b0, 1'b1, 16'hFFFF, 16'hFFFF));
    words_to_send.push_back(make_push(1'b0, 1'b0, 0, 1));
    words_to_send.push_back(make_push(1'b1, 1'b1, 16'h1234, 1));
    words_to_send.push_back(make_push(1'b1, 1'b0, 16'h8000, 0));
    words_to_send.push_back(make_drain(1'b1, 0));
    words_to_send.push_back(make_drain(1'b0, MAX_BATCH));
    // Seventeen pushes to one ring: the last one finds it full.
    for (int unsigned i = 0; i <= RING_DEPTH; i++)
      words_to_send.push_back(make_push(1'b1, 1'b1, 16'hA500 + i, 1));
    words_to_send.push_back(make_drain(1'b1, 127));
    settle();

    set_config(24'hFFFFFF, MAX_BATCH, 1'b0);
    run_random(100, 75, 300, 4, 1'b1);
    set_config(BYTE_CAP_RST, 1, 1'b0);
    run_random(80, 60, 65535, 6, 1'b1);
    set_config(0, 127, 1'b0);
    run_random(40, 60, 3, 4, 1'b1);

    // Fill up with large frames, then drop the cap below the pending total.
    set_config(24'hFFFFFF, 2, 1'b0);
    run_random(30, 100, 65535, 4, 1'b0);
    write_reg(CFG_BYTE_CAP, 24'd1000);
    run_random(50, 60, 500, 4, 1'b1);

    // Closed queue with a zero default batch: drains still go through.
    set_config(BYTE_CAP_RST, 0, 1'b1);
    run_random(40, 50, 1000, 8, 1'b1);
    set_config(200000, DEFAULT_BATCH_RST, 1'b0);
    run_random(100, 65, 4000, 8, 1'b0);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bcpsq_pkg.sv
rtl/core/byte_capped_priority_send_queue.sv
tb/sv/tb.sv
